// ===== hw/rtl/nncr_pkg.sv =====
package nncr_pkg;

    localparam int COORD_W     = 11;
    localparam int PATCH_REG_W = 8;
    localparam int COLOR_W     = 8;
    localparam int DEST_W      = 16;
    localparam int FETCH_W     = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 64;
    localparam int OUT_USER_W  = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_BOX_X_MIN    = 3'd1;
    localparam t_cfg_idx CFG_BOX_Y_MIN    = 3'd2;
    localparam t_cfg_idx CFG_BOX_X_MAX    = 3'd3;
    localparam t_cfg_idx CFG_BOX_Y_MAX    = 3'd4;
    localparam t_cfg_idx CFG_PATCH_WIDTH  = 3'd5;
    localparam t_cfg_idx CFG_PATCH_HEIGHT = 3'd6;

    localparam logic [COORD_W-1:0]     RST_FRAME_WIDTH  = 11'd320;
    localparam logic [COORD_W-1:0]     RST_BOX_X_MIN    = 11'd0;
    localparam logic [COORD_W-1:0]     RST_BOX_Y_MIN    = 11'd0;
    localparam logic [COORD_W-1:0]     RST_BOX_X_MAX    = 11'd48;
    localparam logic [COORD_W-1:0]     RST_BOX_Y_MAX    = 11'd48;
    localparam logic [PATCH_REG_W-1:0] RST_PATCH_WIDTH  = 8'd48;
    localparam logic [PATCH_REG_W-1:0] RST_PATCH_HEIGHT = 8'd48;

endpackage

// ===== hw/rtl/nncr_serdiv.sv =====
module nncr_serdiv #(
    parameter int DVW = 8,
    parameter int HW  = 7,
    parameter int QW  = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HW+QW-1:0]  i_dividend,
    input  logic [DVW-1:0]    i_divisor,
    output logic [QW-1:0]     o_quotient,
    output logic              o_busy
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DVW-1:0]  r_rem;
    logic [QW-1:0]   r_sh;
    logic [DVW-1:0]  r_div;
    logic [CNTW-1:0] r_cnt;

    logic [DVW:0]    trial;
    logic            ge;
    logic [DVW:0]    diff;

    // one quotient bit per cycle, restoring form
    assign trial = {r_rem, r_sh[QW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // high part is below the divisor, so it seeds the remainder
            r_rem <= DVW'(i_dividend[HW+QW-1:QW]);
            r_sh  <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
            r_sh  <= {r_sh[QW-2:0], ge};
        end
    end

    assign o_quotient = r_sh;
    assign o_busy     = r_cnt != '0;

endmodule

// ===== hw/rtl/nncr_addr.sv =====
module nncr_addr (
    input  logic                          i_clk,
    input  logic [nncr_pkg::COORD_W-1:0]  i_frame_width,
    input  logic [nncr_pkg::COORD_W-1:0]  i_x_min,
    input  logic [nncr_pkg::COORD_W-1:0]  i_y_min,
    input  logic [nncr_pkg::COORD_W-1:0]  i_qx,
    input  logic [nncr_pkg::COORD_W-1:0]  i_qy,
    output logic [nncr_pkg::FETCH_W-1:0]  o_fetch_index
);
    import nncr_pkg::*;

    logic [COORD_W:0]   sx;
    logic [COORD_W:0]   sy;
    logic [2*COORD_W:0] prod_full;
    logic [FETCH_W-1:0] r_prod;
    logic [COORD_W:0]   r_sx;
    logic [FETCH_W-1:0] lin;
    logic [FETCH_W-1:0] r_idx;

    assign sx        = {1'b0, i_x_min} + {1'b0, i_qx};
    assign sy        = {1'b0, i_y_min} + {1'b0, i_qy};
    assign prod_full = sy * i_frame_width;

    // index wraps at the fetch width, so only the low bits are kept
    assign lin = r_prod + FETCH_W'(r_sx);

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full[FETCH_W-1:0];
        r_sx   <= sx;
        r_idx  <= lin + {lin[FETCH_W-2:0], 1'b0};
    end

    assign o_fetch_index = r_idx;

endmodule

// ===== hw/rtl/nearest_neighbor_crop_resize_engine.sv =====
// channel   direction  tdata (low bit up)                          tuser / tlast
// s_axis    in         pixel_red, pixel_green, pixel_blue          tuser: action
// m_axis    out        dest_index, out_red, out_green, out_blue,   tuser: write_valid,
//                      fetch_index, 2 bits zero                    fetch_valid, crop_empty;
//                                                                  tlast: last_pixel
// cfg       in         i_cfg_addr selects register, i_cfg_wdata holds the value
//
// a request that asks for a fetch runs from accept to the next ready through these steps:
// accept, operand load, the two bit-serial dividers (one per axis),
// the address multiply and index registers, and the handoff to the output register.
// every other request goes from accept straight to the handoff to the output register.
// reset is synchronous and returns registers to their defaults and the engine to idle.
// a stalled output holds its result; a new request is taken while it waits.
module nearest_neighbor_crop_resize_engine #(
    parameter int PATCH_DIM_MAX = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [nncr_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [nncr_pkg::COORD_W-1:0]      i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_red, pixel_green, pixel_blue
    input  logic [nncr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // dest_index, out_red, out_green, out_blue, fetch_index, zero pad
    output logic [nncr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // write_valid, fetch_valid, crop_empty
    output logic [nncr_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    output logic                              m_axis_tlast
);
    import nncr_pkg::*;

    localparam int PW  = $clog2(PATCH_DIM_MAX + 1);
    localparam int CW  = (PATCH_DIM_MAX > 1) ? $clog2(PATCH_DIM_MAX) : 1;
    localparam int PRW = CW + COORD_W;
    localparam int LW  = CW + PW + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_DIV  = 5'b00100,
        S_ADDR = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [COORD_W-1:0]     r_frame_width;
    logic [COORD_W-1:0]     r_box_x_min;
    logic [COORD_W-1:0]     r_box_y_min;
    logic [COORD_W-1:0]     r_box_x_max;
    logic [COORD_W-1:0]     r_box_y_max;
    logic [PATCH_REG_W-1:0] r_patch_width;
    logic [PATCH_REG_W-1:0] r_patch_height;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic          r_busy;

    logic               r_wr;
    logic [DEST_W-1:0]  r_dest;
    logic [COLOR_W-1:0] r_red;
    logic [COLOR_W-1:0] r_green;
    logic [COLOR_W-1:0] r_blue;
    logic               r_fetch;
    logic               r_last;
    logic               r_empty;
    logic [CW-1:0]      r_kx;
    logic [CW-1:0]      r_ky;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_USER_W-1:0] r_m_user;
    logic                  r_m_last;

    logic [PW-1:0] pw;
    logic [PW-1:0] ph;

    logic               accept;
    logic [CW:0]        col_inc;
    logic [CW:0]        row_inc;
    logic [CW:0]        nrow;
    logic [LW-1:0]      lin;
    logic [CW-1:0]      n_col;
    logic [CW-1:0]      n_row;
    logic               n_busy;
    logic               n_wr;
    logic [DEST_W-1:0]  n_dest;
    logic               n_fetch;
    logic               n_last;
    logic               n_empty;
    logic [CW-1:0]      n_kx;
    logic [CW-1:0]      n_ky;

    logic               x_ok;
    logic               y_ok;
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] wy;
    logic [PRW-1:0]     dvd_x;
    logic [PRW-1:0]     dvd_y;
    logic [PW-1:0]      dvs_x;
    logic [PW-1:0]      dvs_y;
    logic               div_start;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic               busy_x;
    logic               busy_y;
    logic [FETCH_W-1:0] fetch_index;
    logic               out_load;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_box_x_min    <= RST_BOX_X_MIN;
            r_box_y_min    <= RST_BOX_Y_MIN;
            r_box_x_max    <= RST_BOX_X_MAX;
            r_box_y_max    <= RST_BOX_Y_MAX;
            r_patch_width  <= RST_PATCH_WIDTH;
            r_patch_height <= RST_PATCH_HEIGHT;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_BOX_X_MIN:    r_box_x_min    <= i_cfg_wdata;
                CFG_BOX_Y_MIN:    r_box_y_min    <= i_cfg_wdata;
                CFG_BOX_X_MAX:    r_box_x_max    <= i_cfg_wdata;
                CFG_BOX_Y_MAX:    r_box_y_max    <= i_cfg_wdata;
                CFG_PATCH_WIDTH:  r_patch_width  <= i_cfg_wdata[PATCH_REG_W-1:0];
                CFG_PATCH_HEIGHT: r_patch_height <= i_cfg_wdata[PATCH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // patch size saturates at the largest supported patch
    assign pw = ({1'b0, r_patch_width} > (PATCH_REG_W + 1)'(PATCH_DIM_MAX)) ?
                PW'(PATCH_DIM_MAX) : PW'(r_patch_width);
    assign ph = ({1'b0, r_patch_height} > (PATCH_REG_W + 1)'(PATCH_DIM_MAX)) ?
                PW'(PATCH_DIM_MAX) : PW'(r_patch_height);

    assign s_axis_tready = r_state == S_IDLE;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;
    assign lin     = LW'(r_row) * LW'(pw) + LW'(r_col);

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_busy  = r_busy;
        n_wr    = 1'b0;
        n_dest  = '0;
        n_fetch = 1'b0;
        n_last  = 1'b0;
        n_empty = 1'b0;
        n_kx    = '0;
        n_ky    = '0;
        nrow    = {1'b0, r_row};
        if (!s_axis_tuser) begin
            n_col  = '0;
            n_row  = '0;
            n_busy = 1'b0;
            if (r_box_x_max <= r_box_x_min || r_box_y_max <= r_box_y_min) begin
                n_empty = 1'b1;
            end else if (pw != '0 && ph != '0) begin
                n_busy  = 1'b1;
                n_fetch = 1'b1;
            end
        end else if (r_busy) begin
            n_wr   = 1'b1;
            n_dest = DEST_W'({lin, 1'b0} + {1'b0, lin});
            if (col_inc < (CW + 1)'(pw)) begin
                n_col = col_inc[CW-1:0];
                nrow  = {1'b0, r_row};
            end else begin
                n_col = '0;
                nrow  = row_inc;
            end
            // counters at or past the patch size end the crop
            if (nrow >= (CW + 1)'(ph) || (CW + 1)'(n_col) >= (CW + 1)'(pw)) begin
                n_busy = 1'b0;
                n_col  = '0;
                n_row  = '0;
                n_last = 1'b1;
            end else begin
                n_row   = nrow[CW-1:0];
                n_fetch = 1'b1;
                n_kx    = n_col;
                n_ky    = nrow[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_busy <= 1'b0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr    <= n_wr;
            r_dest  <= n_dest;
            r_red   <= n_wr ? s_axis_tdata[COLOR_W-1:0] : '0;
            r_green <= n_wr ? s_axis_tdata[2*COLOR_W-1:COLOR_W] : '0;
            r_blue  <= n_wr ? s_axis_tdata[3*COLOR_W-1:2*COLOR_W] : '0;
            r_fetch <= n_fetch;
            r_last  <= n_last;
            r_empty <= n_empty;
            r_kx    <= n_kx;
            r_ky    <= n_ky;
        end
    end

    // divider operands; an empty axis divides zero and yields zero offset
    assign wx    = r_box_x_max - r_box_x_min;
    assign wy    = r_box_y_max - r_box_y_min;
    assign x_ok  = (r_box_x_max > r_box_x_min) && (pw != '0);
    assign y_ok  = (r_box_y_max > r_box_y_min) && (ph != '0);
    assign dvd_x = x_ok ? PRW'(r_kx) * PRW'(wx) : '0;
    assign dvd_y = y_ok ? PRW'(r_ky) * PRW'(wy) : '0;
    assign dvs_x = x_ok ? pw : PW'(1);
    assign dvs_y = y_ok ? ph : PW'(1);

    assign div_start = r_state == S_LOAD;

    nncr_serdiv #(
        .DVW (PW),
        .HW  (CW),
        .QW  (COORD_W)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_x),
        .i_divisor  (dvs_x),
        .o_quotient (qx),
        .o_busy     (busy_x)
    );

    nncr_serdiv #(
        .DVW (PW),
        .HW  (CW),
        .QW  (COORD_W)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_y),
        .i_divisor  (dvs_y),
        .o_quotient (qy),
        .o_busy     (busy_y)
    );

    nncr_addr u_addr (
        .i_clk         (i_clk),
        .i_frame_width (r_frame_width),
        .i_x_min       (r_box_x_min),
        .i_y_min       (r_box_y_min),
        .i_qx          (qx),
        .i_qy          (qy),
        .o_fetch_index (fetch_index)
    );

    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = n_fetch ? S_LOAD : S_DONE;
                end
            end
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                // address stage captures the quotients on the exit cycle
                if (!busy_x && !busy_y) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {2'b00, (r_fetch ? fetch_index : FETCH_W'(0)),
                         r_blue, r_green, r_red, r_dest};
            r_m_user <= {r_empty, r_fetch, r_wr};
            r_m_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule
